// ===== sv/bfsu_pkg.sv =====
// ----------------------------------------------------------------------------
// bfsu_pkg
// shared types and codes for the bounded fifo with search and update
// ----------------------------------------------------------------------------
package bfsu_pkg;

  localparam int DEPTH_DEFAULT    = 16;
  localparam int KEY_BITS_DEFAULT = 64;

  localparam int OP_BITS     = 3;
  localparam int FIELD_BITS  = 64;
  localparam int STATUS_BITS = 2;
  localparam int POS_BITS    = 5;

  localparam logic [OP_BITS-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_BITS-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_BITS-1:0] OP_SEARCH = 3'd2;
  localparam logic [OP_BITS-1:0] OP_UPDATE = 3'd3;
  localparam logic [OP_BITS-1:0] OP_DUMP   = 3'd4;

  localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_SHIFT,
    CELL_ROTATE
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      replace;
  } cell_ctl_t;

endpackage

// ===== sv/bfsu_if.sv =====
// ----------------------------------------------------------------------------
// bfsu request and response channels
// valid/ready channels carrying one item each
// ----------------------------------------------------------------------------
interface bfsu_req_if import bfsu_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OP_BITS-1:0]    op;
  logic [FIELD_BITS-1:0] key;
  logic [FIELD_BITS-1:0] new_value;

  modport source (output valid, op, key, new_value, input ready);
  modport sink   (input valid, op, key, new_value, output ready);
endinterface

interface bfsu_rsp_if import bfsu_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic [POS_BITS-1:0]    position;
  logic [FIELD_BITS-1:0]  entry_value;
  logic                   last;

  modport source (output valid, status, position, entry_value, last, input ready);
  modport sink   (input valid, status, position, entry_value, last, output ready);
endinterface

// ===== sv/bounded_fifo_search_update.sv =====
// ----------------------------------------------------------------------------
// bounded_fifo_search_update
// bounded fifo of keys with search, update and dump
// ----------------------------------------------------------------------------
// req carries op, key and new_value; rsp returns status, position,
// entry_value and last, with last set on the final result of an item.
// entries sit in a row of cells with the head in the first cell; a delete
// shifts the row one place toward the head.
// insert and delete: one result per accepted item.
// search and update: the occupied cells rotate one place per cycle past the
// head cell while rsp does not stall, count places in all, so the order is
// restored when the result appears.
// dump: the same rotation gives count results, one per cycle while rsp
// does not stall.
// one item is worked on at a time; req.ready is high only between items
// and out of reset.
// when rsp stalls, the rotation waits with the result held in the output
// register, so nothing is lost or repeated.
// reset empties the queue at once; cell contents are not cleared and are
// never read before they are written.
// ----------------------------------------------------------------------------
module bounded_fifo_search_update import bfsu_pkg::*; #(
  parameter int DEPTH    = DEPTH_DEFAULT,
  parameter int KEY_BITS = KEY_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  bfsu_req_if.sink   req,
  bfsu_rsp_if.source rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic                state;
  logic [OP_BITS-1:0]  op;
  logic [KEY_BITS-1:0] key;
  logic [KEY_BITS-1:0] new_value;
  logic [CW-1:0]       count;
  logic [CW-1:0]       step;
  logic                found;
  logic [CW-1:0]       found_pos;

  logic                   o_valid;
  logic [STATUS_BITS-1:0] o_status;
  logic [POS_BITS-1:0]    o_pos;
  logic [FIELD_BITS-1:0]  o_value;
  logic                   o_last;

  logic                state_next;
  logic [CW-1:0]       count_next;
  logic [CW-1:0]       step_next;
  logic                found_next;
  logic [CW-1:0]       found_pos_next;
  logic                emit;
  logic [STATUS_BITS-1:0] e_status;
  logic [POS_BITS-1:0]    e_pos;
  logic [FIELD_BITS-1:0]  e_value;
  logic                   e_last;

  cell_ctl_t           ctl;
  logic [KEY_BITS-1:0] wr_data;
  logic [KEY_BITS-1:0] cell_q [DEPTH];
  logic [KEY_BITS-1:0] head;
  logic                can_go;
  logic                is_last;
  logic                match;
  logic [CW-1:0]       step_pos;

  assign head     = cell_q[0];
  assign can_go   = (state == S_RUN) && (!o_valid || rsp.ready);
  assign is_last  = (step == count - CW'(1));
  assign match    = (head == key) && !found;
  assign step_pos = step + CW'(1);
  assign wr_data  = (op == OP_INSERT) ? key : new_value;

  assign req.ready       = (state == S_IDLE) && !rst;
  assign rsp.valid       = o_valid;
  assign rsp.status      = o_status;
  assign rsp.position    = o_pos;
  assign rsp.entry_value = o_value;
  assign rsp.last        = o_last;

  always_comb begin
    state_next     = state;
    count_next     = count;
    step_next      = step;
    found_next     = found;
    found_pos_next = found_pos;
    ctl            = '{cmd: CELL_HOLD, replace: 1'b0};
    emit           = 1'b0;
    e_status       = ST_OK;
    e_pos          = '0;
    e_value        = '0;
    e_last         = 1'b1;
    if (state == S_IDLE) begin
      if (req.valid) begin
        state_next     = S_RUN;
        step_next      = '0;
        found_next     = 1'b0;
        found_pos_next = '0;
      end
    end else if (can_go) begin
      unique case (op)
        OP_INSERT: begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (count == CW'(DEPTH)) begin
            e_status = ST_FULL;
          end else begin
            ctl.cmd    = CELL_WRITE;
            count_next = count + CW'(1);
          end
        end
        OP_DELETE: begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (count == '0) begin
            e_status = ST_EMPTY;
          end else begin
            ctl.cmd    = CELL_SHIFT;
            count_next = count - CW'(1);
          end
        end
        OP_SEARCH, OP_UPDATE: begin
          if (count == '0) begin
            emit       = 1'b1;
            e_status   = ST_EMPTY;
            state_next = S_IDLE;
          end else begin
            ctl.cmd     = CELL_ROTATE;
            ctl.replace = match && (op == OP_UPDATE);
            if (match) begin
              found_next     = 1'b1;
              found_pos_next = step_pos;
            end
            if (is_last) begin
              emit       = 1'b1;
              state_next = S_IDLE;
              if (match) begin
                e_pos = POS_BITS'(step_pos);
              end else if (found) begin
                e_pos = POS_BITS'(found_pos);
              end else begin
                e_status = ST_NOTFOUND;
              end
            end else begin
              step_next = step_pos;
            end
          end
        end
        OP_DUMP: begin
          emit = 1'b1;
          if (count == '0) begin
            e_status   = ST_EMPTY;
            state_next = S_IDLE;
          end else begin
            ctl.cmd = CELL_ROTATE;
            e_pos   = POS_BITS'(step_pos);
            e_value = FIELD_BITS'(head);
            e_last  = is_last;
            if (is_last) begin
              state_next = S_IDLE;
            end else begin
              step_next = step_pos;
            end
          end
        end
        default: begin
          state_next = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      step      <= '0;
      found     <= 1'b0;
      found_pos <= '0;
      o_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      step      <= step_next;
      found     <= found_next;
      found_pos <= found_pos_next;
      if (emit) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op        <= req.op;
      key       <= req.key[KEY_BITS-1:0];
      new_value <= req.new_value[KEY_BITS-1:0];
    end
    if (emit) begin
      o_status <= e_status;
      o_pos    <= e_pos;
      o_value  <= e_value;
      o_last   <= e_last;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0] nxt;
    if (i == DEPTH - 1) begin : g_end
      assign nxt = head;
    end else begin : g_mid
      assign nxt = cell_q[i+1];
    end
    bfsu_cell #(
      .INDEX    (i),
      .CW       (CW),
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count),
      .wr_data   (wr_data),
      .next_data (nxt),
      .head_data (head),
      .data      (cell_q[i])
    );
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count == $past(count)) || (count == $past(count) + CW'(1)) ||
    (count == $past(count) - CW'(1)))
    else $error("entry count jumped");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> (count == $past(count)))
    else $error("entry count changed while idle");

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!o_valid || rsp.ready))
    else $error("result overwrote a pending item");

endmodule

// ===== sv/bfsu_cell.sv =====
// ----------------------------------------------------------------------------
// bfsu_cell
// one queue slot; loads a key, shifts toward the head or rotates the ring
// ----------------------------------------------------------------------------
module bfsu_cell import bfsu_pkg::*; #(
  parameter int INDEX    = 0,
  parameter int CW       = 5,
  parameter int KEY_BITS = KEY_BITS_DEFAULT
) (
  input  logic                clk,
  input  cell_ctl_t           ctl,
  input  logic [CW-1:0]       count,
  input  logic [KEY_BITS-1:0] wr_data,
  input  logic [KEY_BITS-1:0] next_data,
  input  logic [KEY_BITS-1:0] head_data,
  output logic [KEY_BITS-1:0] data
);

  logic [CW-1:0] idx;
  logic [CW-1:0] idx_plus;

  assign idx      = CW'(INDEX);
  assign idx_plus = CW'(INDEX + 1);

  always_ff @(posedge clk) begin
    unique case (ctl.cmd)
      CELL_WRITE: begin
        if (count == idx) begin
          data <= wr_data;
        end
      end
      CELL_SHIFT: begin
        data <= next_data;
      end
      CELL_ROTATE: begin
        if (idx_plus < count) begin
          data <= next_data;
        end else if (idx_plus == count) begin
          data <= ctl.replace ? wr_data : head_data;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== verif/tb_bounded_fifo_search_update.sv =====
// ----------------------------------------------------------------------------
// tb_bounded_fifo_search_update
// self-checking bench for the bounded fifo with search, update and dump
// ----------------------------------------------------------------------------
// a queue-based model in the scoreboard class predicts every result of each
// accepted request and checks the responses in order, field by field.
// a directed opening covers the empty and full corners, a match at the tail,
// a repeated key, a miss, a full dump and two unused opcodes. random traffic
// follows in four phases of sender idling and receiver back-pressure. keys
// come mostly from entries held at the time, so searches and updates hit.
// ----------------------------------------------------------------------------
module tb_bounded_fifo_search_update;
  import bfsu_pkg::*;

  localparam int PERIOD    = 4;
  localparam int DEPTH     = DEPTH_DEFAULT;
  localparam int N_RANDOM  = 125;
  localparam int POOL_SIZE = 6;

  localparam logic [OP_BITS-1:0] OP_RESERVED_LO = 3'd5;
  localparam logic [OP_BITS-1:0] OP_RESERVED_HI = 3'd7;
  localparam logic [FIELD_BITS-1:0] KEY_MASK =
    {FIELD_BITS{1'b1}} >> (FIELD_BITS - KEY_BITS_DEFAULT);

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [POS_BITS-1:0]    position;
    logic [FIELD_BITS-1:0]  entry_value;
    logic                   last;
  } reply_t;

  class fifo_scoreboard;
    logic [FIELD_BITS-1:0] held[$];
    reply_t                owed_replies[$];
    int                    errors;
    int                    ops_taken;
    int                    replies_checked;
    int                    status_seen[4];

    function void owe(logic [STATUS_BITS-1:0] status, int pos,
                      logic [FIELD_BITS-1:0] value, logic last);
      reply_t r;
      r.status      = status;
      r.position    = pos[POS_BITS-1:0];
      r.entry_value = value;
      r.last        = last;
      owed_replies.push_back(r);
      status_seen[status]++;
    endfunction

    // predicts the replies of one accepted request and updates the queue
    function void note_op(logic [OP_BITS-1:0] op, logic [FIELD_BITS-1:0] key,
                          logic [FIELD_BITS-1:0] new_value);
      logic [FIELD_BITS-1:0] k;
      int                    hit;
      k = key & KEY_MASK;
      hit = -1;
      ops_taken++;
      case (op)
        OP_INSERT: begin
          if (held.size() >= DEPTH) begin
            owe(ST_FULL, 0, '0, 1'b1);
          end else begin
            held.push_back(k);
            owe(ST_OK, 0, '0, 1'b1);
          end
        end
        OP_DELETE: begin
          if (held.size() == 0) begin
            owe(ST_EMPTY, 0, '0, 1'b1);
          end else begin
            void'(held.pop_front());
            owe(ST_OK, 0, '0, 1'b1);
          end
        end
        OP_SEARCH, OP_UPDATE: begin
          for (int i = 0; i < held.size() && hit < 0; i++)
            if (held[i] == k) hit = i;
          if (held.size() == 0) begin
            owe(ST_EMPTY, 0, '0, 1'b1);
          end else if (hit < 0) begin
            owe(ST_NOTFOUND, 0, '0, 1'b1);
          end else begin
            if (op == OP_UPDATE) held[hit] = new_value & KEY_MASK;
            owe(ST_OK, hit + 1, '0, 1'b1);
          end
        end
        OP_DUMP: begin
          if (held.size() == 0) begin
            owe(ST_EMPTY, 0, '0, 1'b1);
          end else begin
            for (int i = 0; i < held.size(); i++)
              owe(ST_OK, i + 1, held[i], i == held.size() - 1);
          end
        end
        default: begin
          // unused opcodes give nothing and change nothing
        end
      endcase
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      replies_checked++;
      if (owed_replies.size() == 0) begin
        errors++;
        if (errors <= 30)
          $display("%0t: result with none expected: status %0d pos %0d value %h last %0d",
                   $time, got.status, got.position, got.entry_value, got.last);
      end else begin
        want = owed_replies.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 30)
            $display("%0t: expected status %0d pos %0d value %h last %0d, got status %0d pos %0d value %h last %0d",
                     $time, want.status, want.position, want.entry_value, want.last,
                     got.status, got.position, got.entry_value, got.last);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  bfsu_req_if req_ch ();
  bfsu_rsp_if rsp_ch ();

  bounded_fifo_search_update u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  fifo_scoreboard        sb = new();
  int                    send_idle_pct = 0;
  int                    recv_stall_pct = 0;
  logic [FIELD_BITS-1:0] key_pool[POOL_SIZE];

  always #(PERIOD / 2) clk = ~clk;

  initial begin
    #(PERIOD * 400000);
    $display("bounded_fifo_search_update: mismatch");
    $finish;
  end

  // receiver back-pressure
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_reply({rsp_ch.status, rsp_ch.position, rsp_ch.entry_value, rsp_ch.last});
  end

  task automatic send_op(logic [OP_BITS-1:0] op, logic [FIELD_BITS-1:0] key,
                         logic [FIELD_BITS-1:0] new_value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid     = 1'b1;
    req_ch.op        = op;
    req_ch.key       = key;
    req_ch.new_value = new_value;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_op(op, key, new_value);
  endtask

  // hold off the sender until every owed result is back
  task automatic drain_replies(int guard);
    int n;
    n = 0;
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (sb.owed_replies.size() != 0 && n < guard) begin
      @(posedge clk);
      n++;
    end
  endtask

  function automatic logic [FIELD_BITS-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [FIELD_BITS-1:0] pick_key(bit for_insert);
    int r;
    r = $urandom_range(99);
    if (!for_insert && r < 55 && sb.held.size() != 0)
      return sb.held[$urandom_range(sb.held.size() - 1)];
    if (r < 80)
      return key_pool[$urandom_range(POOL_SIZE - 1)];
    return rand_word();
  endfunction

  // fill-leaning or drain-leaning mix so the level sweeps both ends
  function automatic logic [OP_BITS-1:0] pick_op(bit filling);
    int r;
    r = $urandom_range(99);
    if (r < 4) return OP_RESERVED_LO + 3'($urandom_range(2));
    if (r < 14) return OP_DUMP;
    if (r < 30) return OP_SEARCH;
    if (r < 44) return OP_UPDATE;
    if (r < 86) return filling ? OP_INSERT : OP_DELETE;
    return filling ? OP_DELETE : OP_INSERT;
  endfunction

  initial begin
    logic [FIELD_BITS-1:0] dup_key;
    logic [FIELD_BITS-1:0] tail_key;
    logic [OP_BITS-1:0]    op;
    bit                    filling;
    int                    wait_n;

    req_ch.valid     = 1'b0;
    req_ch.op        = OP_INSERT;
    req_ch.key       = '0;
    req_ch.new_value = '0;
    key_pool = '{'0, '1, 64'd1, 64'h8000_0000_0000_0000, rand_word(), rand_word()};
    dup_key  = 64'hA5A5_5A5A_C3C3_3C3C;
    tail_key = '1;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty corners, fill to full, tail match, repeated key, miss
    send_op(OP_DELETE, '0, '0);
    send_op(OP_SEARCH, dup_key, '0);
    send_op(OP_UPDATE, dup_key, '1);
    send_op(OP_DUMP, '0, '0);
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) send_op(OP_INSERT, '0, '0);
      else if (i == DEPTH - 1) send_op(OP_INSERT, tail_key, '0);
      else if (i == 3 || i == 9) send_op(OP_INSERT, dup_key, '0);
      else send_op(OP_INSERT, rand_word(), rand_word());
    end
    send_op(OP_INSERT, dup_key, '0);
    send_op(OP_SEARCH, tail_key, '0);
    send_op(OP_UPDATE, dup_key, 64'h0F0F_F0F0_1234_8765);
    send_op(OP_SEARCH, 64'h0123_4567_89AB_CDEF, '0);
    send_op(OP_DUMP, '0, '0);
    send_op(OP_RESERVED_LO, dup_key, '1);
    send_op(OP_RESERVED_HI, '1, '0);
    drain_replies(200000);

    // random traffic over the idling phases
    filling = 1'b0;
    for (int i = 0; i < N_RANDOM; i++) begin
      case ((i * 4) / N_RANDOM)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      if (sb.held.size() == DEPTH || sb.held.size() == 0 || $urandom_range(15) == 0)
        filling = (sb.held.size() < DEPTH / 2);
      op = pick_op(filling);
      send_op(op, pick_key(op == OP_INSERT), rand_word());
      if (i == N_RANDOM / 2) drain_replies(200000);
    end

    drain_replies(300000);
    repeat (DEPTH + 8) @(posedge clk);

    wait_n = sb.owed_replies.size();
    if (wait_n != 0)
      $display("%0t: %0d results never arrived", $time, wait_n);
    $display("ran %0d requests and checked %0d results across four idling phases",
             sb.ops_taken, sb.replies_checked);
    $display("predicted statuses: ok %0d, full %0d, empty %0d, not found %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_FULL],
             sb.status_seen[ST_EMPTY], sb.status_seen[ST_NOTFOUND]);
    if (sb.errors == 0 && wait_n == 0) begin
      $display("bounded_fifo_search_update: match");
    end else begin
      $display("bounded_fifo_search_update: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bfsu_pkg.sv
sv/bfsu_if.sv
sv/bfsu_cell.sv
sv/bounded_fifo_search_update.sv
verif/tb_bounded_fifo_search_update.sv
